>>> rtl/sha1_pkg.sv
// Shared types, constants and round functions of the SHA-1 digest block.
// Depends on nothing; used by the channel interfaces, the RAM users and the top level.
package sha1_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned WordW      = 32;
  localparam int unsigned BufDepth   = 16;
  localparam int unsigned ChainDepth = 5;
  localparam int unsigned NumRounds  = 80;
  localparam int unsigned PosW       = 3;

  localparam logic [7:0] PadMark = 8'h80;

  // Initial chaining value for one word of the hash state.
  function automatic word_t chain_init(logic [2:0] idx);
    word_t v;
    unique case (idx)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hEFCDAB89;
      3'd2:    v = 32'h98BADCFE;
      3'd3:    v = 32'h10325476;
      default: v = 32'hC3D2E1F0;
    endcase
    return v;
  endfunction

  function automatic word_t round_k(logic [6:0] r);
    word_t k;
    if (r < 7'd20) begin
      k = 32'h5A827999;
    end else if (r < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (r < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  // Choose, parity or majority, depending on the round group.
  function automatic word_t round_f(logic [6:0] r, word_t b, word_t c, word_t d);
    word_t f;
    if (r < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (r < 7'd40 || r >= 7'd60) begin
      f = b ^ c ^ d;
    end else begin
      f = (b & c) | (b & d) | (c & d);
    end
    return f;
  endfunction

endpackage

>>> rtl/sha1_if.sv
// Valid/ready channel interfaces for the SHA-1 digest block: message bytes in, digest words out.
// Depends on sha1_pkg for the word type and field widths.
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output message_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input message_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

interface sha1_out_if;
  logic                       valid;
  logic                       ready;
  sha1_pkg::word_t            digest_word;
  logic [sha1_pkg::PosW-1:0]  word_position;
  logic                       final_word;

  modport source (output valid, output digest_word, output word_position,
                  output final_word, input ready);
  modport sink   (input valid, input digest_word, input word_position,
                  input final_word, output ready);
endinterface

>>> rtl/sha1_digest.sv
// SHA-1 digest engine over a byte stream, top level.
// Depends on sha1_pkg, sha1_if (channel interfaces) and sha1_ram (block buffer, chain words).
// Usage:
//   msg_i carries one transaction per message item: an optional byte (byte_present)
//   and an end mark (end_of_message). A bare end mark closes a message, so an empty
//   message is allowed. dig_o returns five 32-bit digest words per message, most
//   significant first, with word_position 0..4 and final_word on the last one.
// Flow:
//   A byte that does not complete a 64-byte block leaves msg_i ready. The 64th
//   byte starts a compression (fetch the chain words, 80 rounds, add and write back)
//   with msg_i not ready; throughput over a full block is set by the round loop and
//   the single read port of each RAM.
//   An end mark adds padding writes, one or two compressions, then a chain read and
//   an output load per digest word. The input reopens once the last word sits in
//   the output register, so the next message may start while it waits.
// Reset:
//   Asynchronous, active low. Chain words read as the initial hash values until a
//   compression writes them (per-word valid bits); byte count and control clear.
// Stall:
//   A stalled dig_o holds the current word; the engine waits before loading the
//   next one and loses nothing.
module sha1_digest (
  input  logic               clk_i,
  input  logic               rst_ni,
  sha1_in_if.sink            msg_i,
  sha1_out_if.source         dig_o
);

  localparam int unsigned BufAw   = $clog2(sha1_pkg::BufDepth);
  localparam int unsigned ChainAw = $clog2(sha1_pkg::ChainDepth);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD_MARK, S_PAD_FILL, S_LOAD, S_ROUND, S_STORE, S_EMIT_RD, S_EMIT_LD
  } state_e;

  // What follows the compression that is running.
  typedef enum logic [1:0] {
    PAD_NONE, PAD_MARK, PAD_FILL, PAD_DONE
  } pad_e;

  state_e                  state_q;
  pad_e                    pad_q;
  logic [6:0]              cnt_q;
  logic [BufAw-1:0]        ptr_q;
  logic                    tail_q;
  logic [60:0]             byte_cnt_q;
  logic [4:0]              chain_vld_q;
  logic                    out_valid_q;

  // Datapath registers, no reset.
  sha1_pkg::word_t         word_q;
  sha1_pkg::word_t         a_q, b_q, c_q, d_q, e_q;
  sha1_pkg::word_t         win_q [16];
  logic [ChainAw-1:0]      rd_addr_q;
  sha1_pkg::word_t         out_word_q;
  logic [sha1_pkg::PosW-1:0] out_pos_q;
  logic                    out_final_q;

  // RAM ports.
  logic                    buf_we, buf_re;
  logic [BufAw-1:0]        buf_waddr, buf_raddr;
  sha1_pkg::word_t         buf_wdata, buf_rdata;
  logic                    chain_we, chain_re;
  logic [ChainAw-1:0]      chain_waddr, chain_raddr;
  sha1_pkg::word_t         chain_wdata, chain_rdata;

  logic                    acc, out_acc, out_free, out_load;
  logic [5:0]              fill;
  logic [BufAw-1:0]        mark_idx;
  sha1_pkg::word_t         byte_word, mark_word, fill_word, chain_val, sched_w, temp;

  assign acc      = msg_i.valid && msg_i.ready;
  assign out_acc  = out_valid_q && dig_o.ready;
  assign out_free = !out_valid_q || dig_o.ready;
  assign out_load = (state_q == S_EMIT_LD) && out_free;
  assign fill     = byte_cnt_q[5:0];
  assign mark_idx = fill[5:2];

  assign msg_i.ready         = (state_q == S_IDLE);
  assign dig_o.valid         = out_valid_q;
  assign dig_o.digest_word   = out_word_q;
  assign dig_o.word_position = out_pos_q;
  assign dig_o.final_word    = out_final_q;

  // Merge the incoming byte (or the pad mark) into the partial big-endian word.
  assign byte_word = ((fill[1:0] == 2'd0) ? '0 : word_q) |
                     ({msg_i.message_byte, 24'h0} >> {fill[1:0], 3'b000});
  assign mark_word = ((fill[1:0] == 2'd0) ? '0 : word_q) |
                     ({sha1_pkg::PadMark, 24'h0} >> {fill[1:0], 3'b000});

  // Zero words, then the 64-bit bit length in the last two words when it fits.
  always_comb begin
    fill_word = '0;
    if (tail_q && ptr_q == BufAw'(14)) begin
      fill_word = byte_cnt_q[60:29];
    end else if (tail_q && ptr_q == BufAw'(15)) begin
      fill_word = {byte_cnt_q[28:0], 3'b000};
    end
  end

  // An unwritten chain word reads as its initial value.
  assign chain_val = chain_vld_q[rd_addr_q] ? chain_rdata : sha1_pkg::chain_init(rd_addr_q);

  // Message schedule: first 16 words straight from the buffer, then from the window.
  always_comb begin
    sha1_pkg::word_t x;
    x = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
    sched_w = (cnt_q < 7'd16) ? buf_rdata : {x[30:0], x[31]};
  end

  assign temp = {a_q[26:0], a_q[31:27]} + sha1_pkg::round_f(cnt_q, b_q, c_q, d_q) + e_q +
                sha1_pkg::round_k(cnt_q) + sched_w;

  // RAM control.
  always_comb begin
    buf_we      = 1'b0;
    buf_waddr   = mark_idx;
    buf_wdata   = byte_word;
    buf_re      = 1'b0;
    buf_raddr   = '0;
    chain_we    = 1'b0;
    chain_waddr = rd_addr_q;
    chain_wdata = chain_val + a_q;
    chain_re    = 1'b0;
    chain_raddr = cnt_q[ChainAw-1:0];
    case (state_q)
      S_IDLE: begin
        buf_we = acc && msg_i.byte_present && (fill[1:0] == 2'd3);
      end
      S_PAD_MARK: begin
        buf_we    = 1'b1;
        buf_wdata = mark_word;
      end
      S_PAD_FILL: begin
        buf_we    = 1'b1;
        buf_waddr = ptr_q;
        buf_wdata = fill_word;
      end
      S_LOAD: begin
        chain_re = (cnt_q < 7'(sha1_pkg::ChainDepth));
        buf_re   = (cnt_q == 7'(sha1_pkg::ChainDepth));
      end
      S_ROUND: begin
        buf_re    = (cnt_q < 7'(sha1_pkg::BufDepth - 1));
        buf_raddr = cnt_q[BufAw-1:0] + BufAw'(1);
      end
      S_STORE: begin
        chain_re = (cnt_q < 7'(sha1_pkg::ChainDepth));
        chain_we = (cnt_q != 7'd0);
      end
      S_EMIT_RD: begin
        chain_re = 1'b1;
      end
      default: ;
    endcase
  end

  // Control state machine and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pad_q       <= PAD_NONE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      tail_q      <= 1'b0;
      byte_cnt_q  <= '0;
      chain_vld_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Load a new word, or drop valid once the current one is taken.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      if (chain_we) begin
        chain_vld_q[chain_waddr] <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (msg_i.byte_present) begin
              byte_cnt_q <= byte_cnt_q + 61'd1;
            end
            if (msg_i.byte_present && fill == 6'd63) begin
              // Block full: compress first, pad afterwards if this ends the message.
              state_q <= S_LOAD;
              cnt_q   <= '0;
              pad_q   <= msg_i.end_of_message ? PAD_MARK : PAD_NONE;
            end else if (msg_i.end_of_message) begin
              state_q <= S_PAD_MARK;
            end
          end
        end
        S_PAD_MARK: begin
          if (mark_idx == BufAw'(15)) begin
            // No room left for the length: it goes into an extra block.
            state_q <= S_LOAD;
            cnt_q   <= '0;
            pad_q   <= PAD_FILL;
          end else begin
            ptr_q   <= mark_idx + BufAw'(1);
            tail_q  <= (mark_idx <= BufAw'(13));
            state_q <= S_PAD_FILL;
          end
        end
        S_PAD_FILL: begin
          if (ptr_q == BufAw'(15)) begin
            state_q <= S_LOAD;
            cnt_q   <= '0;
            pad_q   <= tail_q ? PAD_DONE : PAD_FILL;
          end else begin
            ptr_q <= ptr_q + BufAw'(1);
          end
        end
        S_LOAD: begin
          if (cnt_q == 7'(sha1_pkg::ChainDepth)) begin
            state_q <= S_ROUND;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        S_ROUND: begin
          if (cnt_q == 7'(sha1_pkg::NumRounds - 1)) begin
            state_q <= S_STORE;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        S_STORE: begin
          if (cnt_q == 7'(sha1_pkg::ChainDepth)) begin
            cnt_q <= '0;
            unique case (pad_q)
              PAD_NONE: state_q <= S_IDLE;
              PAD_MARK: state_q <= S_PAD_MARK;
              PAD_FILL: begin
                state_q <= S_PAD_FILL;
                ptr_q   <= '0;
                tail_q  <= 1'b1;
              end
              PAD_DONE: begin
                state_q    <= S_EMIT_RD;
                byte_cnt_q <= '0;
              end
              default: state_q <= S_IDLE;
            endcase
            pad_q <= PAD_NONE;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        S_EMIT_RD: begin
          state_q <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (out_free) begin
            if (cnt_q == 7'(sha1_pkg::ChainDepth - 1)) begin
              // Last word latched: restart from the initial hash values.
              chain_vld_q <= '0;
              cnt_q       <= '0;
              state_q     <= S_IDLE;
            end else begin
              cnt_q   <= cnt_q + 7'd1;
              state_q <= S_EMIT_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath: byte packing, working variables, schedule window, output word.
  always_ff @(posedge clk_i) begin
    if (chain_re) begin
      rd_addr_q <= chain_raddr;
    end
    if (acc && msg_i.byte_present) begin
      word_q <= byte_word;
    end
    case (state_q)
      S_LOAD: begin
        // Shift chain words in: after five, a..e hold words 0..4.
        if (cnt_q != 7'd0) begin
          a_q <= b_q;
          b_q <= c_q;
          c_q <= d_q;
          d_q <= e_q;
          e_q <= chain_val;
        end
      end
      S_ROUND: begin
        a_q <= temp;
        b_q <= a_q;
        c_q <= {b_q[1:0], b_q[31:2]};
        d_q <= c_q;
        e_q <= d_q;
        for (int i = 0; i < 15; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[15] <= sched_w;
      end
      S_STORE: begin
        // Advance the working words in step with the write-back.
        if (cnt_q != 7'd0) begin
          a_q <= b_q;
          b_q <= c_q;
          c_q <= d_q;
          d_q <= e_q;
        end
      end
      S_EMIT_LD: begin
        if (out_free) begin
          out_word_q  <= chain_rdata;
          out_pos_q   <= cnt_q[sha1_pkg::PosW-1:0];
          out_final_q <= (cnt_q == 7'(sha1_pkg::ChainDepth - 1));
        end
      end
      default: ;
    endcase
  end

  sha1_ram #(
    .Width (sha1_pkg::WordW),
    .Depth (sha1_pkg::BufDepth)
  ) u_buf_ram (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  sha1_ram #(
    .Width (sha1_pkg::WordW),
    .Depth (sha1_pkg::ChainDepth)
  ) u_chain_ram (
    .clk_i   (clk_i),
    .we_i    (chain_we),
    .waddr_i (chain_waddr),
    .wdata_i (chain_wdata),
    .re_i    (chain_re),
    .raddr_i (chain_raddr),
    .rdata_o (chain_rdata)
  );

`ifndef NO_ASSERTIONS
  // The write-back never touches the chain word being read in the same cycle.
  a_chain_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_we && chain_re) |-> (chain_waddr != chain_raddr))
    else $error("chain RAM read and write hit the same word");

  // Rounds run uninterrupted up to the last one.
  a_round_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && cnt_q != 7'(sha1_pkg::NumRounds - 1)) |=> (state_q == S_ROUND))
    else $error("round sequence left early");

  // The last digest word carries the last position.
  a_final_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dig_o.valid && dig_o.final_word) |-> (dig_o.word_position == 3'(sha1_pkg::ChainDepth - 1)))
    else $error("final digest word at wrong position");

  // Input is not ready while the rounds or the write-back of a compression run.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND || state_q == S_STORE) |-> !msg_i.ready)
    else $error("input accepted during compression");
`endif

endmodule

>>> rtl/sha1_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing; instantiated by the SHA-1 top level for the block buffer and chain words.
module sha1_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Hold read data when no read is issued.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
